[sv/ilha_pkg.sv]
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types, constants and helpers of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_HEAP_BYTES  = 65536;
    localparam int DEF_CHUNK_BYTES = 4096;

    // Datapath word: tags and byte addresses use full 32-bit arithmetic
    localparam int WORD_W = 32;
    typedef logic [WORD_W-1:0] t_word;

    // Tag layout: size in the upper bits, allocated flag in bit 0
    localparam t_word TAG_MASK  = ~t_word'(7);
    localparam t_word ALLOC_BIT = t_word'(1);

    // Function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // Size field of a tag word
    function automatic t_word tag_size(input t_word w);
        return w & TAG_MASK;
    endfunction

endpackage

[sv/ilha_ram.sv]
// ----------------------------------------------------------------------------
// ilha_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module ilha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ilha_alu.sv]
// ----------------------------------------------------------------------------
// ilha_alu
// Shared 32-bit adder/subtractor with borrow flag for unsigned compares.
// ----------------------------------------------------------------------------
module ilha_alu import ilha_pkg::*; (
    input  t_alu_op i_op,
    input  t_word   i_a,
    input  t_word   i_b,
    output t_word   o_y,
    output logic    o_borrow
);

    logic              sub;
    t_word             b_eff;
    logic [WORD_W:0]   sum;

    // a + b, or a + ~b + 1 for subtract; borrow means a < b
    always_comb begin
        sub      = (i_op == ALU_SUB);
        b_eff    = sub ? ~i_b : i_b;
        sum      = {1'b0, i_a} + {1'b0, b_eff} + {{WORD_W{1'b0}}, sub};
        o_y      = sum[WORD_W-1:0];
        o_borrow = sub & ~sum[WORD_W];
    end

endmodule

[sv/implicit_list_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_top
// First-fit heap allocator with boundary tags over a single-port word RAM.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue an allocate or a free; the result
// word appears on o_payload_addr/o_status for exactly one cycle with o_done
// and must be taken then, since the block cannot be stalled. Every memory
// access goes through the one RAM port and every add and subtract, and most
// compares, through one shared 32-bit adder, so an item is handled as a
// sequence of steps: walking the block headers, then growing, coalescing and
// splitting (a free checks the header and coalesces). After reset the block
// clears and initializes the heap RAM, one word a cycle, which keeps busy
// high until the last word is written.
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_top import ilha_pkg::*; #(
    parameter int HEAP_BYTES  = DEF_HEAP_BYTES,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_block_addr,
    output logic        o_done,
    output logic [15:0] o_payload_addr,
    output logic [1:0]  o_status
);

    // Heap geometry and the initial image
    localparam int  NWORDS   = HEAP_BYTES / 4;
    localparam int  IW       = $clog2(NWORDS);
    localparam int  CH8      = ((CHUNK_BYTES + 7) / 8) * 8;
    localparam bit  FITS     = (CH8 <= HEAP_BYTES) && (16 <= HEAP_BYTES - CH8);
    localparam int  BRK0     = FITS ? 16 + CH8 : 16;
    localparam int  FOOT_IDX = (8 + CH8) / 4;
    localparam int  EPI_IDX  = (12 + CH8) / 4;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DEC,
        S_FF_CHK, S_FF_RD, S_FF_EV, S_FF_NX,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_MP, S_MN, S_MV, S_MT, S_MW1, S_MW2,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_clr_idx;
    t_word           r_brk;
    t_word           r_bp;
    t_word           r_need;
    t_word           r_size;
    t_word           r_psize;
    t_word           r_nsize;
    t_word           r_nxt;
    t_word           r_prv;
    t_word           r_t;
    t_word           r_lim;
    logic [15:0]     r_req;
    logic            r_pa;
    logic            r_na;
    logic            r_ok;
    logic            r_split;
    logic            r_to_take;
    logic            r_oob;

    // Shared adder and RAM hookup
    t_alu_op         alu_op;
    t_word           alu_a;
    t_word           alu_b;
    t_word           alu_y;
    logic            alu_borrow;
    logic            alu_oob;
    logic            wr_req;
    logic            mem_we;
    logic [IW-1:0]   mem_addr;
    t_word           mem_wdata;
    t_word           ram_rdata;
    t_word           rd_word;
    t_word           rd_tag;
    t_word           init_word;
    t_word           take_sz;
    logic            case_pf;

    ilha_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    ilha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (ram_rdata)
    );

    // Reads past the heap return zero
    assign rd_word = r_oob ? '0 : ram_rdata;
    assign rd_tag  = tag_size(rd_word);
    assign alu_oob = (alu_y >= t_word'(HEAP_BYTES));
    assign take_sz = r_split ? r_need : r_size;
    assign case_pf = !r_pa && r_na;
    assign busy    = (r_state != S_IDLE);

    // Initial heap image word for the clearing pass
    always_comb begin
        init_word = '0;
        if (r_clr_idx == IW'(1) || r_clr_idx == IW'(2)) begin
            init_word = t_word'(9);
        end else if (r_clr_idx == IW'(3)) begin
            init_word = FITS ? t_word'(CH8) : ALLOC_BIT;
        end else if (FITS && r_clr_idx == IW'(FOOT_IDX)) begin
            init_word = t_word'(CH8);
        end else if (FITS && r_clr_idx == IW'(EPI_IDX)) begin
            init_word = ALLOC_BIT;
        end
    end

    // Adder operands and memory controls per step
    always_comb begin
        alu_op    = ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;
        wr_req    = 1'b0;
        mem_wdata = '0;
        unique case (r_state)
            S_DEC: begin
                alu_a = t_word'(r_req);
                alu_b = t_word'(15);
            end
            S_FF_CHK: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = r_brk;
            end
            S_FF_RD, S_M0, S_T0: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = t_word'(4);
            end
            S_FF_EV: begin
                alu_op = ALU_SUB; alu_a = rd_tag; alu_b = r_need;
            end
            S_FF_NX: begin
                alu_a = r_bp; alu_b = r_size;
            end
            S_G0: begin
                alu_op = ALU_SUB; alu_a = t_word'(CH8); alu_b = r_need;
            end
            S_G1: begin
                alu_op = ALU_SUB; alu_a = t_word'(HEAP_BYTES); alu_b = r_size;
            end
            S_G2: begin
                alu_op = ALU_SUB; alu_a = r_lim; alu_b = r_brk;
            end
            S_G3: begin
                alu_a = r_brk; alu_b = r_size;
            end
            S_G4, S_F3: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = t_word'(4);
                wr_req = 1'b1; mem_wdata = r_size;
            end
            S_G5: begin
                alu_op = ALU_SUB; alu_a = r_lim; alu_b = t_word'(8);
                wr_req = 1'b1; mem_wdata = r_size;
            end
            S_G6: begin
                alu_op = ALU_SUB; alu_a = r_lim; alu_b = t_word'(4);
                wr_req = 1'b1; mem_wdata = ALLOC_BIT;
            end
            S_M1: begin
                alu_a = r_bp; alu_b = rd_tag;
            end
            S_M2: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = t_word'(8);
            end
            S_M3: begin
                alu_op = ALU_SUB; alu_a = r_nxt; alu_b = t_word'(4);
            end
            S_MP: begin
                alu_a = r_size; alu_b = r_psize;
            end
            S_MN: begin
                alu_a = r_size; alu_b = r_nsize;
            end
            S_MV: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = r_psize;
            end
            S_MT: begin
                alu_a = r_nxt; alu_b = r_nsize;
            end
            S_MW1: begin
                alu_op = ALU_SUB; wr_req = 1'b1; mem_wdata = r_size;
                if (case_pf) begin
                    alu_a = r_nxt; alu_b = t_word'(8);
                end else begin
                    alu_a = r_pa ? r_bp : r_prv; alu_b = t_word'(4);
                end
            end
            S_MW2: begin
                alu_op = ALU_SUB; wr_req = 1'b1; mem_wdata = r_size;
                if (case_pf) begin
                    alu_a = r_prv; alu_b = t_word'(4);
                end else begin
                    alu_a = r_na ? r_nxt : r_t; alu_b = t_word'(8);
                end
            end
            S_T1: begin
                alu_op = ALU_SUB; alu_a = rd_tag; alu_b = r_need;
            end
            S_T2: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = t_word'(4);
                wr_req = 1'b1; mem_wdata = take_sz | ALLOC_BIT;
            end
            S_T3: begin
                alu_a = r_bp; alu_b = take_sz;
            end
            S_T4: begin
                alu_op = ALU_SUB; alu_a = r_t; alu_b = t_word'(8);
                wr_req = 1'b1; mem_wdata = take_sz | ALLOC_BIT;
            end
            S_T5: begin
                alu_op = ALU_SUB; alu_a = r_t; alu_b = t_word'(4);
                wr_req = 1'b1; mem_wdata = r_lim;
            end
            S_T6: begin
                alu_a = r_bp; alu_b = r_size;
            end
            S_T7: begin
                alu_op = ALU_SUB; alu_a = r_t; alu_b = t_word'(8);
                wr_req = 1'b1; mem_wdata = r_lim;
            end
            S_F0: begin
                alu_op = ALU_SUB; alu_a = r_bp; alu_b = t_word'(4);
            end
            S_F1: begin
                alu_op = ALU_SUB; alu_a = r_brk; alu_b = rd_tag;
            end
            S_F2: begin
                alu_op = ALU_SUB; alu_a = r_lim; alu_b = r_bp;
            end
            S_F4: begin
                alu_a = r_bp; alu_b = r_size;
            end
            S_F5: begin
                alu_op = ALU_SUB; alu_a = r_t; alu_b = t_word'(8);
                wr_req = 1'b1; mem_wdata = r_size;
            end
            default: begin
            end
        endcase
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_idx;
            mem_wdata = init_word;
        end else begin
            mem_we    = wr_req & ~alu_oob;
            mem_addr  = alu_y[IW+1:2];
        end
    end

    // Sequencer: state, working registers and the result word
    always_ff @(posedge i_clk) begin
        r_oob  <= alu_oob;
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_brk     <= t_word'(BRK0);
            r_to_take <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + IW'(1);
                    if (r_clr_idx == IW'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_request_size;
                        r_bp  <= t_word'(i_block_addr);
                        r_state <= (i_func == FUNC_FREE) ? S_F0 : S_DEC;
                    end
                end
                // Allocate: block size, then first-fit walk
                S_DEC: begin
                    if (r_req == 16'd0) begin
                        o_done <= 1'b1; o_payload_addr <= '0; o_status <= ST_ZERO;
                        r_state <= S_IDLE;
                    end else begin
                        r_need  <= (r_req <= 16'd8) ? t_word'(16) : (alu_y & TAG_MASK);
                        r_bp    <= t_word'(8);
                        r_state <= S_FF_CHK;
                    end
                end
                S_FF_CHK: r_state <= alu_borrow ? S_FF_RD : S_G0;
                S_FF_RD:  r_state <= S_FF_EV;
                S_FF_EV: begin
                    r_size <= rd_tag;
                    if (rd_tag == '0) begin
                        r_state <= S_G0;
                    end else if (!rd_word[0] && !alu_borrow) begin
                        r_state <= S_T0;
                    end else begin
                        r_state <= S_FF_NX;
                    end
                end
                S_FF_NX: begin
                    r_bp <= alu_y; r_state <= S_FF_CHK;
                end
                // Grow the break
                S_G0: begin
                    r_size  <= alu_borrow ? r_need : t_word'(CH8);
                    r_state <= S_G1;
                end
                S_G1, S_G2: begin
                    if (alu_borrow) begin
                        o_done <= 1'b1; o_payload_addr <= '0; o_status <= ST_FULL;
                        r_state <= S_IDLE;
                    end else begin
                        r_lim   <= alu_y;
                        r_state <= (r_state == S_G1) ? S_G2 : S_G3;
                    end
                end
                S_G3: begin
                    r_brk <= alu_y; r_lim <= alu_y; r_bp <= r_brk; r_state <= S_G4;
                end
                S_G4: r_state <= S_G5;
                S_G5: r_state <= S_G6;
                S_G6: begin
                    r_to_take <= 1'b1; r_state <= S_M0;
                end
                // Coalesce with free neighbors
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_size <= rd_tag; r_nxt <= alu_y; r_state <= S_M2;
                end
                S_M2: r_state <= S_M3;
                S_M3: begin
                    r_pa <= rd_word[0]; r_psize <= rd_tag; r_state <= S_M4;
                end
                S_M4: begin
                    r_na <= rd_word[0]; r_nsize <= rd_tag;
                    if (r_pa && rd_word[0]) begin
                        if (r_to_take) begin
                            r_state <= S_T0;
                        end else begin
                            o_done <= 1'b1; o_payload_addr <= '0; o_status <= ST_DONE;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    if (!r_pa) r_size <= alu_y;
                    r_state <= S_MN;
                end
                S_MN: begin
                    if (!r_na) r_size <= alu_y;
                    r_state <= S_MV;
                end
                S_MV: begin
                    r_prv <= alu_y; r_state <= S_MT;
                end
                S_MT: begin
                    r_t <= alu_y; r_state <= S_MW1;
                end
                S_MW1: r_state <= S_MW2;
                S_MW2: begin
                    if (!r_pa) r_bp <= r_prv;
                    if (r_to_take) begin
                        r_state <= S_T0;
                    end else begin
                        o_done <= 1'b1; o_payload_addr <= '0; o_status <= ST_DONE;
                        r_state <= S_IDLE;
                    end
                end
                // Place and split
                S_T0: r_state <= S_T1;
                S_T1: begin
                    r_size  <= rd_tag;
                    r_lim   <= alu_y;
                    r_split <= !alu_borrow && (alu_y[WORD_W-1:4] != '0);
                    r_state <= S_T2;
                end
                S_T2: r_state <= S_T3;
                S_T3: begin
                    r_t <= alu_y; r_state <= S_T4;
                end
                S_T4: begin
                    if (r_split) begin
                        r_state <= S_T5;
                    end else begin
                        o_done <= 1'b1; o_payload_addr <= r_bp[15:0]; o_status <= ST_DONE;
                        r_to_take <= 1'b0; r_state <= S_IDLE;
                    end
                end
                S_T5: r_state <= S_T6;
                S_T6: begin
                    r_t <= alu_y; r_state <= S_T7;
                end
                S_T7: begin
                    o_done <= 1'b1; o_payload_addr <= r_bp[15:0]; o_status <= ST_DONE;
                    r_to_take <= 1'b0; r_state <= S_IDLE;
                end
                // Free: check the header, clear tags, coalesce
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_size  <= rd_tag;
                    r_lim   <= alu_y;
                    r_ok    <= (r_bp[2:0] == 3'd0) && (r_bp >= t_word'(16)) && rd_word[0]
                               && (rd_tag != '0) && !alu_borrow;
                    r_state <= S_F2;
                end
                S_F2: begin
                    if (!r_ok || alu_borrow) begin
                        o_done <= 1'b1; o_payload_addr <= '0; o_status <= ST_DONE;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_F3;
                    end
                end
                S_F3: r_state <= S_F4;
                S_F4: begin
                    r_t <= alu_y; r_state <= S_F5;
                end
                S_F5: begin
                    r_to_take <= 1'b0; r_state <= S_M0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result word while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word did not start work");
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_DONE || o_status == ST_ZERO || o_status == ST_FULL))
        else $error("bad status code");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_payload_addr == 16'd0))
        else $error("payload address on failed request");

endmodule
